[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TBW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent, delayed by the dly argument
`define TBW_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (ante) |-> ##(dly) (cons)) else $error(msg);

`endif

[src/tbw_pkg.sv]
// ----------------------------------------------------------------------------
// tbw_pkg
// Types, widths and constants shared by the barycentric weight pipeline.
// ----------------------------------------------------------------------------
package tbw_pkg;

  // fixed field widths of the item ports
  localparam int COORD_WIDTH = 16;
  localparam int WEIGHT_W    = 32;

  // default fraction bits of the weights, and the weight sum in whole units
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int WEIGHT_ONE       = 1;

  // internal widths derived from the coordinate width
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = SUM_W - 1;

  // pipeline depths
  localparam int EDGE_LAT   = 4;
  localparam int DIV_LAT    = WEIGHT_W + 1;
  localparam int FINISH_LAT = 2;
  localparam int LATENCY    = EDGE_LAT + DIV_LAT + FINISH_LAT;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
  } tbw_in_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_alpha;
    logic signed [WEIGHT_W-1:0] weight_beta;
    logic signed [WEIGHT_W-1:0] weight_gamma;
    logic                       degenerate;
    logic                       saturated;
  } tbw_out_t;

  // edge functions as sign and magnitude, ready for the divider
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic             neg_b;
    logic             neg_g;
    logic [MAG_W-1:0] mag_d;
    logic [MAG_W-1:0] mag_nb;
    logic [MAG_W-1:0] mag_ng;
  } tbw_edge_t;

  // unsigned quotients with overflow marks
  typedef struct packed {
    logic                valid;
    logic                degen;
    logic                neg_b;
    logic                neg_g;
    logic                ov_b;
    logic                ov_g;
    logic [WEIGHT_W-1:0] q_b;
    logic [WEIGHT_W-1:0] q_g;
  } tbw_quot_t;

endpackage

[src/tbw_edge.sv]
// ----------------------------------------------------------------------------
// tbw_edge
// Four stages: coordinate differences, products, edge sums, sign/magnitude.
// ----------------------------------------------------------------------------
module tbw_edge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  tbw_pkg::tbw_in_t   in_data,
  output tbw_pkg::tbw_edge_t edge_o
);

  localparam int DW = tbw_pkg::DIFF_W;
  localparam int PW = tbw_pkg::PROD_W;
  localparam int SW = tbw_pkg::SUM_W;
  localparam int MW = tbw_pkg::MAG_W;

  // stage 1: differences against vertex a
  logic                 v1_r;
  logic signed [DW-1:0] dpx_r, dpy_r, dbx_r, dby_r, dcx_r, dcy_r;
  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] p_bxcy_r, p_cxby_r, p_cypx_r, p_cxpy_r, p_bxpy_r, p_bypx_r;
  // stage 3: doubled area and the two numerators
  logic                 v3_r;
  logic signed [SW-1:0] den_r, nb_r, ng_r;
  // stage 4: sign and magnitude
  logic                 v4_r;
  logic                 degen_r, neg_b_r, neg_g_r;
  logic [MW-1:0]        mag_d_r, mag_nb_r, mag_ng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dpx_r <= DW'(in_data.point_x)    - DW'(in_data.vertex_a_x);
    dpy_r <= DW'(in_data.point_y)    - DW'(in_data.vertex_a_y);
    dbx_r <= DW'(in_data.vertex_b_x) - DW'(in_data.vertex_a_x);
    dby_r <= DW'(in_data.vertex_b_y) - DW'(in_data.vertex_a_y);
    dcx_r <= DW'(in_data.vertex_c_x) - DW'(in_data.vertex_a_x);
    dcy_r <= DW'(in_data.vertex_c_y) - DW'(in_data.vertex_a_y);

    p_bxcy_r <= PW'(dbx_r) * PW'(dcy_r);
    p_cxby_r <= PW'(dcx_r) * PW'(dby_r);
    p_cypx_r <= PW'(dcy_r) * PW'(dpx_r);
    p_cxpy_r <= PW'(dcx_r) * PW'(dpy_r);
    p_bxpy_r <= PW'(dbx_r) * PW'(dpy_r);
    p_bypx_r <= PW'(dby_r) * PW'(dpx_r);

    den_r <= SW'(p_bxcy_r) - SW'(p_cxby_r);
    nb_r  <= SW'(p_cypx_r) - SW'(p_cxpy_r);
    ng_r  <= SW'(p_bxpy_r) - SW'(p_bypx_r);

    degen_r  <= (den_r == '0);
    neg_b_r  <= nb_r[SW-1] ^ den_r[SW-1];
    neg_g_r  <= ng_r[SW-1] ^ den_r[SW-1];
    mag_d_r  <= den_r[SW-1] ? MW'(-den_r) : MW'(den_r);
    mag_nb_r <= nb_r[SW-1]  ? MW'(-nb_r)  : MW'(nb_r);
    mag_ng_r <= ng_r[SW-1]  ? MW'(-ng_r)  : MW'(ng_r);
  end

  always_comb begin
    edge_o.valid  = v4_r;
    edge_o.degen  = degen_r;
    edge_o.neg_b  = neg_b_r;
    edge_o.neg_g  = neg_g_r;
    edge_o.mag_d  = mag_d_r;
    edge_o.mag_nb = mag_nb_r;
    edge_o.mag_ng = mag_ng_r;
  end

endmodule

[src/tbw_divider.sv]
// ----------------------------------------------------------------------------
// tbw_divider
// Pipelined restoring divider, two lanes sharing one divisor, one bit a stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbw_divider #(
  parameter int WFB = tbw_pkg::WEIGHT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbw_pkg::tbw_edge_t edge_i,
  output tbw_pkg::tbw_quot_t quot_o
);

  localparam int QW = tbw_pkg::WEIGHT_W;
  localparam int MW = tbw_pkg::MAG_W;
  localparam int RW = MW + ((WFB > QW) ? WFB : QW);

  typedef struct packed {
    logic degen;
    logic neg_b;
    logic neg_g;
    logic ov_b;
    logic ov_g;
  } side_t;

  logic          v_r     [0:QW];
  side_t         side_r  [0:QW];
  logic [MW-1:0] d_r     [0:QW];
  logic [RW-1:0] rem_b_r [0:QW];
  logic [RW-1:0] rem_g_r [0:QW];
  logic [QW-1:0] q_b_r   [0:QW];
  logic [QW-1:0] q_g_r   [0:QW];

  // entry stage: scale numerators, flag quotients of 2^QW or more
  logic [RW-1:0] num_b, num_g, dtop;

  always_comb begin
    num_b = RW'(edge_i.mag_nb) << WFB;
    num_g = RW'(edge_i.mag_ng) << WFB;
    dtop  = RW'(edge_i.mag_d) << QW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= edge_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r[0].degen <= edge_i.degen;
    side_r[0].neg_b <= edge_i.neg_b;
    side_r[0].neg_g <= edge_i.neg_g;
    side_r[0].ov_b  <= (num_b >= dtop);
    side_r[0].ov_g  <= (num_g >= dtop);
    d_r[0]          <= edge_i.mag_d;
    rem_b_r[0]      <= num_b;
    rem_g_r[0]      <= num_g;
    q_b_r[0]        <= '0;
    q_g_r[0]        <= '0;
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int BIT = QW - 1 - s;

    logic [RW-1:0] dsh;
    logic          ge_b, ge_g;
    logic [RW-1:0] rem_b_nxt, rem_g_nxt;
    logic [QW-1:0] q_b_nxt, q_g_nxt;

    always_comb begin
      dsh       = RW'(d_r[s]) << BIT;
      ge_b      = (rem_b_r[s] >= dsh);
      ge_g      = (rem_g_r[s] >= dsh);
      rem_b_nxt = ge_b ? (rem_b_r[s] - dsh) : rem_b_r[s];
      rem_g_nxt = ge_g ? (rem_g_r[s] - dsh) : rem_g_r[s];
      q_b_nxt   = q_b_r[s] | (QW'(ge_b) << BIT);
      q_g_nxt   = q_g_r[s] | (QW'(ge_g) << BIT);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      side_r[s+1]  <= side_r[s];
      d_r[s+1]     <= d_r[s];
      rem_b_r[s+1] <= rem_b_nxt;
      rem_g_r[s+1] <= rem_g_nxt;
      q_b_r[s+1]   <= q_b_nxt;
      q_g_r[s+1]   <= q_g_nxt;
    end
  end

  always_comb begin
    quot_o.valid = v_r[QW];
    quot_o.degen = side_r[QW].degen;
    quot_o.neg_b = side_r[QW].neg_b;
    quot_o.neg_g = side_r[QW].neg_g;
    quot_o.ov_b  = side_r[QW].ov_b;
    quot_o.ov_g  = side_r[QW].ov_g;
    quot_o.q_b   = q_b_r[QW];
    quot_o.q_g   = q_g_r[QW];
  end

  `TBW_ASSERT_DLY(a_div_valid_flow, edge_i.valid, tbw_pkg::DIV_LAT, quot_o.valid, "divider lost an item")

endmodule

[src/tbw_finish.sv]
// ----------------------------------------------------------------------------
// tbw_finish
// Apply signs, saturate beta and gamma, form and saturate alpha; zero a degenerate item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbw_finish #(
  parameter int WFB = tbw_pkg::WEIGHT_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbw_pkg::tbw_quot_t quot_i,
  output logic               out_valid,
  output tbw_pkg::tbw_out_t  out_data
);

  localparam int QW = tbw_pkg::WEIGHT_W;
  localparam int AW = QW + 2;
  localparam logic signed [AW-1:0] ONE_W = AW'(tbw_pkg::WEIGHT_ONE) << WFB;

  // returns {saturated, weight}
  function automatic logic [QW:0] clip_lane(input logic [QW-1:0] q,
                                            input logic ov, input logic neg);
    logic          sat;
    logic [QW-1:0] val;
    sat = 1'b0;
    val = q;
    if (ov) begin
      sat = 1'b1;
      val = neg ? tbw_pkg::WEIGHT_MIN : tbw_pkg::WEIGHT_MAX;
    end else if (!neg) begin
      if (q[QW-1]) begin
        sat = 1'b1;
        val = tbw_pkg::WEIGHT_MAX;
      end
    end else begin
      if (q[QW-1] && |q[QW-2:0]) begin
        sat = 1'b1;
        val = tbw_pkg::WEIGHT_MIN;
      end else begin
        val = -q;
      end
    end
    return {sat, val};
  endfunction

  // stage A: signed, saturated beta and gamma
  logic                 va_r, degen_r, sat_bg_r;
  logic signed [QW-1:0] beta_r, gamma_r;
  logic [QW:0]          lane_b, lane_g;

  always_comb begin
    lane_b = clip_lane(quot_i.q_b, quot_i.ov_b, quot_i.neg_b);
    lane_g = clip_lane(quot_i.q_g, quot_i.ov_g, quot_i.neg_g);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= quot_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    degen_r  <= quot_i.degen;
    sat_bg_r <= lane_b[QW] | lane_g[QW];
    beta_r   <= lane_b[QW-1:0];
    gamma_r  <= lane_g[QW-1:0];
  end

  // stage B: alpha and the result register
  logic signed [AW-1:0] alpha_sum;
  logic                 alpha_fits;
  logic [QW-1:0]        alpha_w;
  logic                 out_valid_r;
  tbw_pkg::tbw_out_t    out_nxt, out_r;

  always_comb begin
    alpha_sum  = ONE_W - AW'(beta_r) - AW'(gamma_r);
    alpha_fits = (&alpha_sum[AW-1:QW-1]) | ~(|alpha_sum[AW-1:QW-1]);
    if (alpha_fits) begin
      alpha_w = alpha_sum[QW-1:0];
    end else begin
      alpha_w = alpha_sum[AW-1] ? tbw_pkg::WEIGHT_MIN : tbw_pkg::WEIGHT_MAX;
    end
    if (degen_r) begin
      out_nxt.weight_alpha = '0;
      out_nxt.weight_beta  = '0;
      out_nxt.weight_gamma = '0;
      out_nxt.degenerate   = 1'b1;
      out_nxt.saturated    = 1'b0;
    end else begin
      out_nxt.weight_alpha = alpha_w;
      out_nxt.weight_beta  = beta_r;
      out_nxt.weight_gamma = gamma_r;
      out_nxt.degenerate   = 1'b0;
      out_nxt.saturated    = sat_bg_r | ~alpha_fits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TBW_ASSERT_IMP(a_degen_zero, out_valid && out_data.degenerate, !out_data.saturated && out_data.weight_alpha == 0 && out_data.weight_beta == 0, "degenerate item has nonzero weights")

endmodule

[src/triangle_barycentric_weights.sv]
// ----------------------------------------------------------------------------
// triangle_barycentric_weights
// A result strobes on out_valid once a taken item has passed the edge, divider and finish stages.
// Throughput: one item per cycle; busy stays low and the receiver cannot stall.
// The depth is set mostly by the restoring divider, one quotient bit a stage.
// Reset clears only the valid bits of the pipeline; items in flight are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_barycentric_weights #(
  parameter int WEIGHT_FRAC_BITS = tbw_pkg::WEIGHT_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tbw_pkg::tbw_in_t  in_data,
  output logic              out_valid,
  output tbw_pkg::tbw_out_t out_data
);

  // The pipeline never holds: every stage advances each cycle, so take an
  // item whenever start is high.
  logic               in_valid;
  tbw_pkg::tbw_edge_t edge_s;
  tbw_pkg::tbw_quot_t quot_s;

  assign busy     = 1'b0;
  assign in_valid = start & ~busy;

  // Form the doubled area and the beta/gamma numerators as sign and
  // magnitude (four stages).
  tbw_edge u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .edge_o   (edge_s)
  );

  // Divide both numerators by the area magnitude in fixed point; an
  // overflow mark replaces quotient bits beyond the weight width.
  tbw_divider #(
    .WFB (WEIGHT_FRAC_BITS)
  ) u_divider (
    .clk    (clk),
    .rst_n  (rst_n),
    .edge_i (edge_s),
    .quot_o (quot_s)
  );

  // Restore signs, saturate, derive alpha, zero out a degenerate triangle.
  tbw_finish #(
    .WFB (WEIGHT_FRAC_BITS)
  ) u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .quot_i    (quot_s),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // every taken item reaches out_valid after the whole pipeline, and nothing else does
  `TBW_ASSERT_DLY(a_item_out, start && !busy, tbw_pkg::LATENCY, out_valid, "item did not reach the output")
  `TBW_ASSERT_IMP(a_no_ghost, out_valid, $past(start && !busy, tbw_pkg::LATENCY), "result without an item")

endmodule
